/* sv/lhm_pkg.sv */
// Shared types and constants of the latency histogram monitor.
// Holds request kinds, metric codes, register indexes, the controller states
// and the command and status bundles between controller and datapath.
package lhm_pkg;

	// Request kinds carried in the input tuser field.
	localparam logic [1:0] REQ_SUCCESS = 2'd0;
	localparam logic [1:0] REQ_FAIL    = 2'd1;
	localparam logic [1:0] REQ_SHIELD  = 2'd2;
	localparam logic [1:0] REQ_TICK    = 2'd3;

	// Register indexes of the configuration port (word address).
	localparam logic [1:0] REG_ALARM_ENABLE   = 2'd0;
	localparam logic [1:0] REG_FAIL_THRESHOLD = 2'd1;
	localparam logic [1:0] REG_FAIL_RATE      = 2'd2;

	// Latency bucket boundaries in microseconds.
	localparam int unsigned NUM_BUCKETS = 6;
	localparam logic [31:0] BUCKET_LIMIT_0 = 32'd50_000;
	localparam logic [31:0] BUCKET_LIMIT_1 = 32'd100_000;
	localparam logic [31:0] BUCKET_LIMIT_2 = 32'd300_000;
	localparam logic [31:0] BUCKET_LIMIT_3 = 32'd500_000;
	localparam logic [31:0] BUCKET_LIMIT_4 = 32'd1_000_000;

	// Scale factor of the percentage metrics.
	localparam logic [6:0] PERCENT_SCALE = 7'd100;

	// Metric codes in report order.
	typedef enum logic [3:0] {
		MET_TOTAL   = 4'd0,
		MET_SUCCESS = 4'd1,
		MET_FAIL    = 4'd2,
		MET_SHIELD  = 4'd3,
		MET_AVG     = 4'd4,
		MET_MAX     = 4'd5,
		MET_BUCKET0 = 4'd6,
		MET_BUCKET1 = 4'd7,
		MET_BUCKET2 = 4'd8,
		MET_BUCKET3 = 4'd9,
		MET_BUCKET4 = 4'd10,
		MET_BUCKET5 = 4'd11
	} metric_id_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ALARM_MUL,
		ST_ALARM_CMP,
		ST_LOAD,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// Configuration register contents.
	typedef struct packed {
		logic        alarm_enable;
		logic [31:0] fail_count_threshold;
		logic [6:0]  fail_rate_percent;
	} cfg_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic       alarm_mul;
		logic       alarm_cmp;
		logic       div_start;
		logic       emit;
		logic       clear;
		metric_id_t metric;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_tick;
		logic div_busy;
		logic out_free;
	} status_t;

endpackage

/* sv/lhm_divider.sv */
// Bit-serial restoring divider of the latency histogram monitor.
// One quotient bit per cycle; depends on nothing but its parameters.
module lhm_divider #(
	parameter int unsigned NUM_W = 55,
	parameter int unsigned DEN_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] numerator,
	input  logic [DEN_W-1:0] denominator,
	output logic             busy,
	output logic [NUM_W-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0]   trial;
	logic [DEN_W:0]   diff;
	logic             ge;

	// One restoring step: shift in the next numerator bit and try a subtract.
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	assign busy     = cnt_q != '0;
	assign quotient = num_q;

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CNT_W'(NUM_W);
		end else if (busy) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// Numerator shifts out while quotient bits shift in.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= numerator;
			den_q <= denominator;
			rem_q <= '0;
		end else if (busy) begin
			num_q <= {num_q[NUM_W-2:0], ge};
			rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
		end
	end

endmodule

/* sv/lhm_datapath.sv */
// Datapath of the latency histogram monitor: counters, latency sum and maximum,
// bucket counters, alarm evaluation, the divider and the output register.
// Depends on lhm_pkg and lhm_divider.
module lhm_datapath #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned SUM_WIDTH   = 48
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lhm_pkg::cfg_t        cfg,
	input  logic [1:0]           in_req_type,
	input  logic [31:0]          in_latency_us,
	input  lhm_pkg::cmd_t        cmd,
	output lhm_pkg::status_t     status,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic [3:0]           out_metric_id,
	output logic [31:0]          out_metric_value,
	output logic                 out_alarm,
	output logic                 out_last
);

	localparam int unsigned PROD_W = COUNT_WIDTH + 7;
	localparam int unsigned DIV_W  = (SUM_WIDTH > PROD_W) ? SUM_WIDTH : PROD_W;
	localparam int unsigned VAL_W  = DIV_W + 1;
	localparam int unsigned CMP_W  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;

	logic [COUNT_WIDTH-1:0] total_q;
	logic [COUNT_WIDTH-1:0] success_q;
	logic [COUNT_WIDTH-1:0] fail_q;
	logic [COUNT_WIDTH-1:0] shield_q;
	logic [SUM_WIDTH-1:0]   sum_q;
	logic [31:0]            max_q;
	logic [COUNT_WIDTH-1:0] bucket_q [lhm_pkg::NUM_BUCKETS];

	logic [PROD_W-1:0]      prod_fail_q;
	logic [PROD_W-1:0]      prod_rate_q;
	logic                   alarm_q;

	logic                   is_event;
	logic [2:0]             bucket_sel;
	logic [SUM_WIDTH:0]     sum_next;
	logic [2:0]             bucket_rd;
	logic [DIV_W-1:0]       bucket_scaled;
	logic [DIV_W-1:0]       div_num;
	logic [DIV_W-1:0]       quotient;
	logic                   div_busy;
	logic                   total_zero;
	logic [VAL_W-1:0]       value_wide;
	logic [31:0]            value_clip;

	logic                   out_valid_q;
	logic [3:0]             out_metric_q;
	logic [31:0]            out_value_q;
	logic                   out_alarm_q;
	logic                   out_last_q;

	// Input decode.
	assign is_event   = cmd.accept && (in_req_type != lhm_pkg::REQ_TICK);
	assign total_zero = total_q == '0;

	// Bucket of the incoming latency.
	always_comb begin
		priority if (in_latency_us < lhm_pkg::BUCKET_LIMIT_0) begin
			bucket_sel = 3'd0;
		end else if (in_latency_us < lhm_pkg::BUCKET_LIMIT_1) begin
			bucket_sel = 3'd1;
		end else if (in_latency_us < lhm_pkg::BUCKET_LIMIT_2) begin
			bucket_sel = 3'd2;
		end else if (in_latency_us < lhm_pkg::BUCKET_LIMIT_3) begin
			bucket_sel = 3'd3;
		end else if (in_latency_us < lhm_pkg::BUCKET_LIMIT_4) begin
			bucket_sel = 3'd4;
		end else begin
			bucket_sel = 3'd5;
		end
	end

	// Latency sum with a carry bit for saturation.
	assign sum_next = {1'b0, sum_q} + (SUM_WIDTH + 1)'(in_latency_us);

	// Event accumulation; the end of a report clears everything.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			success_q <= '0;
			fail_q    <= '0;
			shield_q  <= '0;
			sum_q     <= '0;
			max_q     <= '0;
			for (int b = 0; b < lhm_pkg::NUM_BUCKETS; b++) begin
				bucket_q[b] <= '0;
			end
		end else if (cmd.clear) begin
			total_q   <= '0;
			success_q <= '0;
			fail_q    <= '0;
			shield_q  <= '0;
			sum_q     <= '0;
			max_q     <= '0;
			for (int b = 0; b < lhm_pkg::NUM_BUCKETS; b++) begin
				bucket_q[b] <= '0;
			end
		end else if (is_event) begin
			if (total_q != '1) begin
				total_q <= total_q + COUNT_WIDTH'(1);
			end
			if (in_req_type == lhm_pkg::REQ_SUCCESS && success_q != '1) begin
				success_q <= success_q + COUNT_WIDTH'(1);
			end
			if (in_req_type == lhm_pkg::REQ_FAIL && fail_q != '1) begin
				fail_q <= fail_q + COUNT_WIDTH'(1);
			end
			if (in_req_type == lhm_pkg::REQ_SHIELD && shield_q != '1) begin
				shield_q <= shield_q + COUNT_WIDTH'(1);
			end
			sum_q <= sum_next[SUM_WIDTH] ? '1 : sum_next[SUM_WIDTH-1:0];
			if (in_latency_us > max_q) begin
				max_q <= in_latency_us;
			end
			for (int b = 0; b < lhm_pkg::NUM_BUCKETS; b++) begin
				if (bucket_sel == 3'(b) && bucket_q[b] != '1) begin
					bucket_q[b] <= bucket_q[b] + COUNT_WIDTH'(1);
				end
			end
		end
	end

	// Alarm: products first, the comparison in the following cycle.
	always_ff @(posedge clk) begin
		if (cmd.alarm_mul) begin
			prod_fail_q <= PROD_W'(fail_q) * PROD_W'(lhm_pkg::PERCENT_SCALE);
			prod_rate_q <= PROD_W'(total_q) * PROD_W'(cfg.fail_rate_percent);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alarm_q <= 1'b0;
		end else if (cmd.alarm_cmp) begin
			alarm_q <= cfg.alarm_enable && !total_zero &&
				(CMP_W'(fail_q) >= CMP_W'(cfg.fail_count_threshold)) &&
				(prod_fail_q >= prod_rate_q);
		end
	end

	// Divider operands: latency sum for the average, scaled bucket count otherwise.
	assign bucket_rd = 3'(cmd.metric - lhm_pkg::MET_BUCKET0);
	always_comb begin
		bucket_scaled = '0;
		if (cmd.metric >= lhm_pkg::MET_BUCKET0) begin
			bucket_scaled = DIV_W'(bucket_q[bucket_rd]) * DIV_W'(lhm_pkg::PERCENT_SCALE);
		end
	end
	assign div_num = (cmd.metric == lhm_pkg::MET_AVG) ? DIV_W'(sum_q) : bucket_scaled;

	lhm_divider #(
		.NUM_W(DIV_W),
		.DEN_W(COUNT_WIDTH)
	) u_divider (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (cmd.div_start),
		.numerator  (div_num),
		.denominator(total_q),
		.busy       (div_busy),
		.quotient   (quotient)
	);

	// Metric value selection, then saturation to 32 bits.
	always_comb begin
		unique case (cmd.metric)
			lhm_pkg::MET_TOTAL:   value_wide = VAL_W'(total_q);
			lhm_pkg::MET_SUCCESS: value_wide = VAL_W'(success_q);
			lhm_pkg::MET_FAIL:    value_wide = VAL_W'(fail_q);
			lhm_pkg::MET_SHIELD:  value_wide = VAL_W'(shield_q);
			lhm_pkg::MET_MAX:     value_wide = VAL_W'(max_q);
			default:              value_wide = total_zero ? '0 : VAL_W'(quotient);
		endcase
	end
	assign value_clip = (|value_wide[VAL_W-1:32]) ? '1 : value_wide[31:0];

	// Output register: loaded on emit, emptied when the consumer takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_metric_q <= cmd.metric;
			out_value_q  <= value_clip;
			out_alarm_q  <= alarm_q;
			out_last_q   <= cmd.metric == lhm_pkg::MET_BUCKET5;
		end
	end

	assign out_valid        = out_valid_q;
	assign out_metric_id    = out_metric_q;
	assign out_metric_value = out_value_q;
	assign out_alarm        = out_alarm_q;
	assign out_last         = out_last_q;

	// Status to the controller.
	assign status.is_tick  = in_req_type == lhm_pkg::REQ_TICK;
	assign status.div_busy = div_busy;
	assign status.out_free = !out_valid_q || out_ready;

	// A metric is never loaded over one that has not been taken.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_valid_q || out_ready))
		else $error("metric loaded into a full output register");

	// The end of a report leaves the interval state empty.
	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clear |=> (total_q == '0 && sum_q == '0 && max_q == '0))
		else $error("interval state not cleared after report");

	// Each request event adds one to the total unless it is saturated.
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(is_event && !cmd.clear && total_q != '1) |=>
		total_q == $past(total_q) + COUNT_WIDTH'(1))
		else $error("total count did not advance on a request event");

	// The divider is started only when it is free.
	a_div_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider restarted while busy");

endmodule

/* sv/lhm_ctrl.sv */
// Controller of the latency histogram monitor: input handshake and the
// report sequence over the twelve metrics. Depends on lhm_pkg.
module lhm_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lhm_pkg::status_t status,
	output lhm_pkg::cmd_t    cmd
);

	lhm_pkg::state_t     state_q;
	lhm_pkg::state_t     state_d;
	lhm_pkg::metric_id_t metric_q;
	logic                accept;
	logic                needs_div;
	logic                last_metric;

	assign accept      = in_valid && (state_q == lhm_pkg::ST_IDLE);
	assign needs_div   = (metric_q == lhm_pkg::MET_AVG) || (metric_q >= lhm_pkg::MET_BUCKET0);
	assign last_metric = metric_q == lhm_pkg::MET_BUCKET5;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lhm_pkg::ST_IDLE: begin
				if (accept && status.is_tick) begin
					state_d = lhm_pkg::ST_ALARM_MUL;
				end
			end
			lhm_pkg::ST_ALARM_MUL: state_d = lhm_pkg::ST_ALARM_CMP;
			lhm_pkg::ST_ALARM_CMP: state_d = lhm_pkg::ST_LOAD;
			lhm_pkg::ST_LOAD: begin
				state_d = needs_div ? lhm_pkg::ST_DIVIDE : lhm_pkg::ST_EMIT;
			end
			lhm_pkg::ST_DIVIDE: begin
				if (!status.div_busy) begin
					state_d = lhm_pkg::ST_EMIT;
				end
			end
			lhm_pkg::ST_EMIT: begin
				if (status.out_free) begin
					state_d = last_metric ? lhm_pkg::ST_IDLE : lhm_pkg::ST_LOAD;
				end
			end
			default: state_d = lhm_pkg::ST_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		in_ready      = state_q == lhm_pkg::ST_IDLE;
		cmd           = '0;
		cmd.metric    = metric_q;
		cmd.accept    = accept;
		cmd.alarm_mul = state_q == lhm_pkg::ST_ALARM_MUL;
		cmd.alarm_cmp = state_q == lhm_pkg::ST_ALARM_CMP;
		cmd.div_start = (state_q == lhm_pkg::ST_LOAD) && needs_div;
		cmd.emit      = (state_q == lhm_pkg::ST_EMIT) && status.out_free;
		cmd.clear     = (state_q == lhm_pkg::ST_EMIT) && status.out_free && last_metric;
	end

	// State and metric counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= lhm_pkg::ST_IDLE;
			metric_q <= lhm_pkg::MET_TOTAL;
		end else begin
			state_q <= state_d;
			if (state_q == lhm_pkg::ST_ALARM_MUL) begin
				metric_q <= lhm_pkg::MET_TOTAL;
			end else if (state_q == lhm_pkg::ST_EMIT && status.out_free && !last_metric) begin
				metric_q <= lhm_pkg::metric_id_t'(metric_q + 4'd1);
			end
		end
	end

endmodule

/* sv/latency_histogram_monitor.sv */
// Latency histogram monitor. Request completion transactions (success, fail,
// shielded) are taken one per clock: each updates the outcome counters, the
// total, the saturating latency sum, the latency maximum and one of six latency
// buckets. A tick transaction starts a report of twelve metric transactions
// (counts, average and maximum latency, bucket percentages), each flagged with
// the fail alarm; while the report runs the input is not ready. The report's length
// is set by the bit-serial divider, DIV_W bits wide (the larger of SUM_WIDTH and
// COUNT_WIDTH + 7), that forms the average and the six percentages one after
// another; a stalled output lengthens the report further.
// The next input is taken as soon as the last metric sits in the output register.
// Depends on lhm_pkg, lhm_ctrl, lhm_datapath and lhm_divider.
module latency_histogram_monitor #(
	parameter int unsigned COUNT_WIDTH = 32,
	parameter int unsigned SUM_WIDTH   = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] latency_us
	input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
	// Metric stream.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] metric_value
	output logic [4:0]  m_axis_tuser,   // [3:0] metric_id, [4] alarm
	output logic        m_axis_tlast,
	// Configuration port.
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	lhm_pkg::cfg_t    cfg_q;
	lhm_pkg::cmd_t    cmd;
	lhm_pkg::status_t status;
	logic             cfg_write;
	logic [1:0]       reg_index;
	logic [3:0]       metric_id;
	logic             alarm;

	// Configuration registers.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;
	assign reg_index = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_index)
				lhm_pkg::REG_ALARM_ENABLE:   cfg_q.alarm_enable         <= pwdata[0];
				lhm_pkg::REG_FAIL_THRESHOLD: cfg_q.fail_count_threshold <= pwdata;
				lhm_pkg::REG_FAIL_RATE:      cfg_q.fail_rate_percent    <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_index)
			lhm_pkg::REG_ALARM_ENABLE:   prdata = {31'd0, cfg_q.alarm_enable};
			lhm_pkg::REG_FAIL_THRESHOLD: prdata = cfg_q.fail_count_threshold;
			lhm_pkg::REG_FAIL_RATE:      prdata = {25'd0, cfg_q.fail_rate_percent};
			default:                     prdata = '0;
		endcase
	end

	lhm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_axis_tvalid),
		.in_ready(s_axis_tready),
		.status  (status),
		.cmd     (cmd)
	);

	lhm_datapath #(
		.COUNT_WIDTH(COUNT_WIDTH),
		.SUM_WIDTH  (SUM_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.in_req_type     (s_axis_tuser),
		.in_latency_us   (s_axis_tdata),
		.cmd             (cmd),
		.status          (status),
		.out_ready       (m_axis_tready),
		.out_valid       (m_axis_tvalid),
		.out_metric_id   (metric_id),
		.out_metric_value(m_axis_tdata),
		.out_alarm       (alarm),
		.out_last        (m_axis_tlast)
	);

	assign m_axis_tuser = {alarm, metric_id};

endmodule
